>>> hw/rtl/red_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package red_pkg;

   localparam int FRAME_W  = 12;
   localparam int PERIOD_W = 16;
   localparam int ADDR_W   = 3;
   localparam int ADDR_SLOTS = 8;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_WARN   = 2'd1,
      ACT_REG    = 2'd2,
      ACT_REMOVE = 2'd3
   } act_type;

   typedef enum logic {
      KIND_RETRACE = 1'b0,
      KIND_WARN    = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      OP_FETCH,
      OP_DECODE,
      OP_WALK,
      OP_FLUSH
   } op_type;

   typedef enum logic [1:0] {
      JC_ALWAYS,
      JC_SLOT_OP,
      JC_WALK_MORE
   } jc_type;

   typedef logic [1:0] step_type;

   typedef struct packed {
      op_type   op;
      jc_type   cond;
      step_type target;
   } ctrl_type;

   // microprogram: fetch, decode (slot ops return to fetch), walk loop, flush
   function automatic ctrl_type rom_word(input step_type step);
      ctrl_type w;
      case (step)
         2'd0:    w = '{op: OP_FETCH,  cond: JC_ALWAYS,    target: 2'd1};
         2'd1:    w = '{op: OP_DECODE, cond: JC_SLOT_OP,   target: 2'd0};
         2'd2:    w = '{op: OP_WALK,   cond: JC_WALK_MORE, target: 2'd2};
         2'd3:    w = '{op: OP_FLUSH,  cond: JC_ALWAYS,    target: 2'd0};
         default: w = '{op: OP_FETCH,  cond: JC_ALWAYS,    target: 2'd1};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/retrace_event_divider.sv
// channel | valid     | stall     | fields
// req     | req_valid | req_stall | req_action, req_slot_index, req_period
// rsp     | rsp_valid | rsp_stall | rsp_target_slot, rsp_event_kind,
//         |           |           | rsp_frame_number, rsp_last
//
// Tick or warning: fetch, decode, a walk over min(NUM_SLOTS, 8) slots, then
// flush; register or remove: fetch and decode only.
// The slot walk is the sequencer's loop step, one slot per cycle unless held.
// Reset is synchronous, active high; no clearing pass is needed.
// One message is held back until the next is found, so last is known; on a
// hit with one held, the walk waits while the output is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module retrace_event_divider #(
   parameter int NUM_SLOTS = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_action,
   input  wire logic [red_pkg::ADDR_W-1:0]  req_slot_index,
   input  wire logic [red_pkg::PERIOD_W-1:0] req_period,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [red_pkg::ADDR_W-1:0]       rsp_target_slot,
   output logic                             rsp_event_kind,
   output logic [red_pkg::FRAME_W-1:0]      rsp_frame_number,
   output logic                             rsp_last
);
   import red_pkg::*;

   localparam int SLOTS_USED = (NUM_SLOTS < ADDR_SLOTS) ? NUM_SLOTS : ADDR_SLOTS;
   localparam int PTR_W = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOTS_USED - 1);
   localparam logic [ADDR_W:0] SLOTS_LIM = (ADDR_W + 1)'(SLOTS_USED);

   step_type             step_ff, step_in;
   act_type              act_ff;
   logic [ADDR_W-1:0]    idx_ff;
   logic [PERIOD_W-1:0]  period_ff;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0]    pend_slot_ff, pend_slot_in;
   kind_type             pend_kind_ff, pend_kind_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 slot_valid_ff [SLOTS_USED];
   logic [PERIOD_W-1:0]  reload_ff     [SLOTS_USED];
   logic [PERIOD_W-1:0]  count_ff      [SLOTS_USED];

   ctrl_type             cw;
   logic                 accept, out_free, hold, cond_true;
   logic                 in_range, hit, cur_valid;
   logic [PERIOD_W-1:0]  cur_count, count_in;
   logic                 count_we, slot_we, valid_we, valid_in;
   logic [PTR_W-1:0]     idx_ptr;

   assign cw        = rom_word(step_ff);
   assign req_stall = (cw.op != OP_FETCH);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_range  = ({1'b0, idx_ff} < SLOTS_LIM);
   assign idx_ptr   = idx_ff[PTR_W-1:0];
   assign cur_valid = slot_valid_ff[ptr_ff];
   assign cur_count = count_ff[ptr_ff];
   assign hit       = cur_valid && ((act_ff == ACT_WARN) || (cur_count == '0));

   always_comb begin
      hold          = 1'b0;
      cond_true     = 1'b0;
      frame_in      = frame_ff;
      ptr_in        = ptr_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_kind_in  = pend_kind_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_last_in   = rsp_last_ff;
      count_in      = cur_count - PERIOD_W'(1);
      count_we      = 1'b0;
      slot_we       = 1'b0;
      valid_we      = 1'b0;
      valid_in      = 1'b0;

      case (cw.op)
         OP_FETCH: begin
            hold = !req_valid;
         end
         OP_DECODE: begin
            ptr_in = '0;
            case (act_ff)
               ACT_TICK: frame_in = frame_ff + FRAME_W'(1);
               ACT_REG: begin
                  slot_we  = in_range;
                  valid_we = in_range;
                  valid_in = 1'b1;
               end
               ACT_REMOVE: begin
                  valid_we = in_range;
                  valid_in = 1'b0;
               end
               default: ;
            endcase
         end
         OP_WALK: begin
            hold = hit && pend_valid_ff && !out_free;
            if (!hold) begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_slot_in  = pend_slot_ff;
                     rsp_kind_in  = pend_kind_ff;
                     rsp_frame_in = frame_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = ADDR_W'(ptr_ff);
                  pend_kind_in  = (act_ff == ACT_WARN) ? KIND_WARN : KIND_RETRACE;
               end
               if ((act_ff == ACT_TICK) && cur_valid) begin
                  count_we = 1'b1;
                  if (cur_count == '0) count_in = reload_ff[ptr_ff];
               end
               ptr_in = ptr_ff + PTR_W'(1);
            end
         end
         OP_FLUSH: begin
            hold = pend_valid_ff && !out_free;
            if (pend_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = pend_slot_ff;
               rsp_kind_in   = pend_kind_ff;
               rsp_frame_in  = frame_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase

      case (cw.cond)
         JC_ALWAYS:    cond_true = 1'b1;
         JC_SLOT_OP:   cond_true = (act_ff == ACT_REG) || (act_ff == ACT_REMOVE);
         JC_WALK_MORE: cond_true = (ptr_ff != PTR_LAST);
         default:      cond_true = 1'b0;
      endcase

      if (hold)           step_in = step_ff;
      else if (cond_true) step_in = cw.target;
      else                step_in = step_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= '0;
         frame_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < SLOTS_USED; i++) slot_valid_ff[i] <= 1'b0;
      end else begin
         step_ff       <= step_in;
         frame_ff      <= frame_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (valid_we) slot_valid_ff[idx_ptr] <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= act_type'(req_action);
         idx_ff    <= req_slot_index;
         period_ff <= req_period;
      end
      ptr_ff       <= ptr_in;
      pend_slot_ff <= pend_slot_in;
      pend_kind_ff <= pend_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_last_ff  <= rsp_last_in;
      if (slot_we) begin
         reload_ff[idx_ptr] <= period_ff - PERIOD_W'(1);
         count_ff[idx_ptr]  <= '0;
      end else if (count_we) begin
         count_ff[ptr_ff] <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_slot  = rsp_slot_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_pend_at_fetch: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_FETCH) |-> !pend_valid_ff)
      else $error("held message left over at fetch");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> (cw.op == OP_DECODE))
      else $error("accepted beat not followed by decode");

   a_register_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ((cw.op == OP_DECODE) && (act_ff == ACT_REG) && in_range)
      |=> slot_valid_ff[$past(idx_ptr)])
      else $error("registered slot not valid");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      (cw.op == OP_WALK) |-> (ptr_ff <= PTR_LAST))
      else $error("walk pointer beyond slot table");
`endif

endmodule

`default_nettype wire
